[design/mrsri_pkg.sv]
`default_nettype none
package mrsri_pkg;
  localparam int FRAME_DEPTH = 8;
  localparam int REG_COUNT = 16;
  localparam int MAX_QTY = 16;
  localparam int BC_W = $clog2(FRAME_DEPTH + 2);
  localparam int FB_AW = $clog2(FRAME_DEPTH);
  localparam int RT_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [0:0] REG_SLAVE_ADDRESS = 1'b0;
  localparam logic [0:0] REG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_RD, S_CHK_CRC, S_CHK_END, S_CHK_HI, S_CHK_LO, S_VALIDATE,
    S_CMD, S_SEND_RD, S_SEND, S_SEND_CRC_LO, S_SEND_CRC_HI
  } state_t;

  typedef enum logic [2:0] {
    SEL_FB, SEL_CMD, SEL_FUNC, SEL_COUNT, SEL_REG_HI, SEL_REG_LO, SEL_CRC_LO, SEL_CRC_HI
  } sel_t;

  typedef struct packed {
    logic       load_item;
    logic       crc_init;
    logic       crc_feed;
    logic       fb_rd;
    logic [FB_AW-1:0] fb_addr;
    logic       rt_rd;
    logic       latch_hdr;
    logic       ptr_inc;
    logic       out_load;
    sel_t       sel;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic       op_byte;
    logic       op_tick;
    logic       op_write;
    logic       frame_end;
    logic [BC_W-1:0] len;
    logic [7:0] fb_data;
    logic       addr_ok;
    logic [15:0] crc;
    logic       req_ok;
    logic       qty_done;
    logic       out_full;
  } stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction
endpackage
`default_nettype wire

[design/mrsri_datapath.sv]
`default_nettype none
module mrsri_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic [1:0] op,
  input  wire logic [7:0] rx_byte,
  input  wire logic frame_error,
  input  wire logic [3:0] reg_index,
  input  wire logic [15:0] reg_value,
  input  wire mrsri_pkg::cmd_t cmd,
  output mrsri_pkg::stat_t stat,
  input  wire logic out_ready,
  output logic out_valid,
  output logic kind,
  output logic [7:0] out_byte,
  output logic last
);
  logic [7:0] slave_address, timeout_ticks;
  logic [7:0] frame_buffer [mrsri_pkg::FRAME_DEPTH];
  logic [15:0] register_table [mrsri_pkg::REG_COUNT];
  logic [mrsri_pkg::REG_COUNT-1:0] reg_valid;
  logic [mrsri_pkg::BC_W-1:0] byte_count, len;
  logic [7:0] silence_count;
  logic timer_running;
  logic pend;
  logic [1:0] op_q;
  logic [7:0] rx_q;
  logic ferr_q;
  logic [3:0] idx_q;
  logic [15:0] val_q;
  logic [7:0] fb_data;
  logic [mrsri_pkg::FB_AW-1:0] fb_addr_q;
  logic [15:0] rt_data, crc;
  logic [7:0] b0, b2, b3, b4, b5;
  logic [mrsri_pkg::RT_AW-1:0] ptr;
  logic [4:0] remain;
  logic [7:0] crc_in;
  logic [7:0] silence_inc;
  logic [16:0] span;

  assign silence_inc = silence_count + 8'd1;
  assign span = {1'b0, b2, b3} + {1'b0, b4, b5};

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      timeout_ticks <= 8'd130;
    end else if (cfg_we) begin
      if (cfg_index == mrsri_pkg::REG_SLAVE_ADDRESS) slave_address <= cfg_data;
      else timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q <= op;
      rx_q <= rx_byte;
      ferr_q <= frame_error;
      idx_q <= reg_index;
      val_q <= reg_value;
    end
  end

  // latched item is applied exactly once, in the cycle after the latch
  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else pend <= cmd.load_item;
  end

  // frame timing, applied the cycle after an item is latched
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      silence_count <= '0;
      timer_running <= 1'b0;
      reg_valid <= '0;
      len <= '0;
    end else if (stat.op_byte) begin
      timer_running <= !ferr_q;
      if (!ferr_q) begin
        if (byte_count <= mrsri_pkg::BC_W'(mrsri_pkg::FRAME_DEPTH))
          byte_count <= byte_count + 1'b1;
        silence_count <= '0;
      end
    end else if (stat.op_tick && timer_running) begin
      silence_count <= silence_inc;
      if (silence_inc == timeout_ticks) begin
        len <= byte_count;
        byte_count <= '0;
        silence_count <= '0;
        timer_running <= 1'b0;
      end
    end else if (stat.op_write && 32'(idx_q) < mrsri_pkg::REG_COUNT) begin
      reg_valid[idx_q[mrsri_pkg::RT_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.op_byte && !ferr_q && byte_count < mrsri_pkg::BC_W'(mrsri_pkg::FRAME_DEPTH))
      frame_buffer[byte_count[mrsri_pkg::FB_AW-1:0]] <= rx_q;
    if (cmd.fb_rd) begin
      fb_data <= frame_buffer[cmd.fb_addr];
      fb_addr_q <= cmd.fb_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.op_write && 32'(idx_q) < mrsri_pkg::REG_COUNT)
      register_table[idx_q[mrsri_pkg::RT_AW-1:0]] <= val_q;
    if (cmd.rt_rd) rt_data <= reg_valid[ptr] ? register_table[ptr] : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_hdr) begin
      unique case (fb_addr_q)
        mrsri_pkg::FB_AW'(0): b0 <= fb_data;
        mrsri_pkg::FB_AW'(2): b2 <= fb_data;
        mrsri_pkg::FB_AW'(3): b3 <= fb_data;
        mrsri_pkg::FB_AW'(4): b4 <= fb_data;
        mrsri_pkg::FB_AW'(5): b5 <= fb_data;
        default: ;
      endcase
    end
    if (cmd.crc_init) begin
      ptr <= mrsri_pkg::RT_AW'(b3);
      remain <= b5[4:0];
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + 1'b1;
      remain <= remain - 5'd1;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      mrsri_pkg::SEL_FB: crc_in = fb_data;
      mrsri_pkg::SEL_CMD: crc_in = b0;
      mrsri_pkg::SEL_FUNC: crc_in = mrsri_pkg::FUNC_READ_INPUT;
      mrsri_pkg::SEL_COUNT: crc_in = {b5[6:0], 1'b0};
      mrsri_pkg::SEL_REG_HI: crc_in = rt_data[15:8];
      mrsri_pkg::SEL_REG_LO: crc_in = rt_data[7:0];
      mrsri_pkg::SEL_CRC_LO: crc_in = crc[7:0];
      mrsri_pkg::SEL_CRC_HI: crc_in = crc[15:8];
      default: crc_in = fb_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.crc_init) crc <= mrsri_pkg::CRC_INIT;
    else if (cmd.crc_feed) crc <= mrsri_pkg::crc_byte(crc, crc_in);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      // only a single-byte command frame is sent straight from the buffer
      kind <= (cmd.sel == mrsri_pkg::SEL_FB);
      out_byte <= crc_in;
      last <= cmd.out_last;
    end
  end

  always_comb begin
    stat.op_byte = pend && (op_q == mrsri_pkg::OP_BYTE);
    stat.op_tick = pend && (op_q == mrsri_pkg::OP_TICK);
    stat.op_write = pend && (op_q == mrsri_pkg::OP_WRITE);
    stat.frame_end = stat.op_tick && timer_running && (silence_inc == timeout_ticks);
    stat.len = len;
    stat.fb_data = fb_data;
    stat.addr_ok = (fb_data == slave_address);
    stat.crc = crc;
    stat.req_ok = (len == mrsri_pkg::BC_W'(8)) && ({b4, b5} != 16'd0)
                  && ({b4, b5} <= 16'(mrsri_pkg::MAX_QTY))
                  && (span <= 17'(mrsri_pkg::REG_COUNT));
    stat.qty_done = (remain == 5'd1);
    stat.out_full = out_valid && !out_ready;
  end
endmodule
`default_nettype wire

[design/mrsri_ctrl.sv]
`default_nettype none
module mrsri_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire mrsri_pkg::stat_t stat,
  output mrsri_pkg::cmd_t cmd
);
  mrsri_pkg::state_t state, state_next;
  logic busy, busy_next;
  logic [mrsri_pkg::FB_AW:0] k, k_next;
  logic hi, hi_next;
  logic fn_ok, fn_ok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrsri_pkg::S_IDLE;
      busy <= 1'b0;
      k <= '0;
      hi <= 1'b0;
      fn_ok <= 1'b0;
    end else begin
      state <= state_next;
      busy <= busy_next;
      k <= k_next;
      hi <= hi_next;
      fn_ok <= fn_ok_next;
    end
  end

  always_comb begin
    state_next = state;
    busy_next = busy;
    k_next = k;
    hi_next = hi;
    fn_ok_next = fn_ok;
    cmd = '0;
    cmd.sel = mrsri_pkg::SEL_FB;
    cmd.fb_addr = k[mrsri_pkg::FB_AW-1:0];
    in_ready = 1'b0;
    unique case (state)
      mrsri_pkg::S_IDLE: begin
        // an item latched last cycle is applied now
        if (busy) begin
          busy_next = 1'b0;
          if (stat.frame_end) begin
            k_next = '0;
            state_next = mrsri_pkg::S_CHK_RD;
          end
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load_item = 1'b1;
            busy_next = 1'b1;
          end
        end
      end
      mrsri_pkg::S_CHK_RD: begin
        cmd.fb_rd = 1'b1;
        cmd.fb_addr = '0;
        cmd.crc_init = 1'b1;
        if (stat.len == '0 || stat.len > mrsri_pkg::BC_W'(mrsri_pkg::FRAME_DEPTH))
          state_next = mrsri_pkg::S_IDLE;
        else if (stat.len == mrsri_pkg::BC_W'(1)) state_next = mrsri_pkg::S_CMD;
        else state_next = mrsri_pkg::S_CHK_CRC;
      end
      mrsri_pkg::S_CMD: begin
        if (!stat.out_full) begin
          cmd.fb_addr = '0;
          cmd.latch_hdr = 1'b1;
          cmd.sel = mrsri_pkg::SEL_FB;
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_next = mrsri_pkg::S_IDLE;
        end
      end
      mrsri_pkg::S_CHK_CRC: begin
        // fb_data holds byte k
        cmd.latch_hdr = 1'b1;
        if (k == '0) begin
          fn_ok_next = 1'b1;
          if (!stat.addr_ok) state_next = mrsri_pkg::S_IDLE;
        end
        if (k == (mrsri_pkg::FB_AW + 1)'(1) && stat.fb_data != mrsri_pkg::FUNC_READ_INPUT)
          fn_ok_next = 1'b0;
        if (state_next != mrsri_pkg::S_IDLE) begin
          cmd.crc_feed = 1'b1;
          k_next = k + 1'b1;
          cmd.fb_rd = 1'b1;
          cmd.fb_addr = k_next[mrsri_pkg::FB_AW-1:0];
          if ({1'b0, k_next} >= (mrsri_pkg::FB_AW + 2)'(stat.len) - 2'd2)
            state_next = mrsri_pkg::S_CHK_LO;
        end
      end
      mrsri_pkg::S_CHK_LO: begin
        if (stat.fb_data != stat.crc[7:0]) state_next = mrsri_pkg::S_IDLE;
        else begin
          k_next = k + 1'b1;
          cmd.fb_rd = 1'b1;
          cmd.fb_addr = k_next[mrsri_pkg::FB_AW-1:0];
          state_next = mrsri_pkg::S_CHK_HI;
        end
      end
      mrsri_pkg::S_CHK_HI: begin
        if (stat.fb_data != stat.crc[15:8] || !fn_ok) state_next = mrsri_pkg::S_IDLE;
        else state_next = mrsri_pkg::S_VALIDATE;
      end
      mrsri_pkg::S_VALIDATE: begin
        cmd.crc_init = 1'b1;
        k_next = '0;
        state_next = stat.req_ok ? mrsri_pkg::S_CHK_END : mrsri_pkg::S_IDLE;
      end
      mrsri_pkg::S_CHK_END: begin
        // header bytes: address, function, byte count
        if (!stat.out_full) begin
          unique case (k[1:0])
            2'd0: cmd.sel = mrsri_pkg::SEL_CMD;
            2'd1: cmd.sel = mrsri_pkg::SEL_FUNC;
            default: cmd.sel = mrsri_pkg::SEL_COUNT;
          endcase
          cmd.crc_feed = 1'b1;
          cmd.out_load = 1'b1;
          k_next = k + 1'b1;
          if (k[1:0] == 2'd2) state_next = mrsri_pkg::S_SEND_RD;
        end
      end
      mrsri_pkg::S_SEND_RD: begin
        cmd.rt_rd = 1'b1;
        hi_next = 1'b1;
        state_next = mrsri_pkg::S_SEND;
      end
      mrsri_pkg::S_SEND: begin
        if (!stat.out_full) begin
          cmd.sel = hi ? mrsri_pkg::SEL_REG_HI : mrsri_pkg::SEL_REG_LO;
          cmd.crc_feed = 1'b1;
          cmd.out_load = 1'b1;
          hi_next = !hi;
          if (!hi) begin
            cmd.ptr_inc = 1'b1;
            state_next = mrsri_pkg::S_SEND_RD;
          end
        end
        if (!hi && !stat.out_full && stat.qty_done) state_next = mrsri_pkg::S_SEND_CRC_LO;
      end
      mrsri_pkg::S_SEND_CRC_LO: begin
        if (!stat.out_full) begin
          cmd.sel = mrsri_pkg::SEL_CRC_LO;
          cmd.out_load = 1'b1;
          state_next = mrsri_pkg::S_SEND_CRC_HI;
        end
      end
      mrsri_pkg::S_SEND_CRC_HI: begin
        if (!stat.out_full) begin
          cmd.sel = mrsri_pkg::SEL_CRC_HI;
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_next = mrsri_pkg::S_IDLE;
        end
      end
      default: state_next = mrsri_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[design/modbus_rtu_slave_read_input_regs_core.sv]
`default_nettype none
// channel | handshake               | payload
// in      | in_valid / in_ready     | op, rx_byte, frame_error, reg_index, reg_value
// out     | out_valid / out_ready   | kind, out_byte, last
// cfg     | cfg_we                  | cfg_index, cfg_data
// A byte, tick or table write is latched first, then applied.
// A closing tick then checks the frame one buffer byte a cycle
// and sends a reply, two bytes per register, each register read from the table first.
// Output stalls hold the sequencer; no new item is taken until the reply is out.
// Synchronous reset: address 1, timeout 130, table reads zero until written.
module modbus_rtu_slave_read_input_regs_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] op,
  input  wire logic [7:0] rx_byte,
  input  wire logic frame_error,
  input  wire logic [3:0] reg_index,
  input  wire logic [15:0] reg_value,
  output logic out_valid,
  input  wire logic out_ready,
  output logic kind,
  output logic [7:0] out_byte,
  output logic last
);
  mrsri_pkg::cmd_t cmd;
  mrsri_pkg::stat_t stat;

  mrsri_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  mrsri_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .op(op), .rx_byte(rx_byte), .frame_error(frame_error), .reg_index(reg_index),
    .reg_value(reg_value), .cmd(cmd), .stat(stat), .out_ready(out_ready),
    .out_valid(out_valid), .kind(kind), .out_byte(out_byte), .last(last)
  );
endmodule
`default_nettype wire

[tb/sv/modbus_rtu_slave_read_input_regs_core_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module modbus_rtu_slave_read_input_regs_core_tb;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       last;
  } reply_byte_t;

  // Reply tracker: shadow of the slave's state and queue of bytes still owed
  class reply_tracker;
    logic [7:0]  frame_mem[mrsri_pkg::FRAME_DEPTH];
    int unsigned rx_count;
    logic [7:0]  quiet_ticks;
    bit          timing;
    logic [15:0] input_regs[mrsri_pkg::REG_COUNT];
    logic [7:0]  my_addr;
    logic [7:0]  close_ticks;
    reply_byte_t owed[$];
    int          errors;

    function void clear();
      foreach (input_regs[i]) input_regs[i] = '0;
      foreach (frame_mem[i]) frame_mem[i] = '0;
      rx_count = 0;
      quiet_ticks = '0;
      timing = 0;
      my_addr = 8'd1;
      close_ticks = 8'd130;
      owed.delete();
      errors = 0;
    endfunction

    function logic [15:0] crc16(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
    endfunction

    function void push(logic k, logic [7:0] b, logic l);
      reply_byte_t r;
      r.kind = k;
      r.out_byte = b;
      r.last = l;
      owed.push_back(r);
    endfunction

    // Judge a closed frame and queue the bytes the slave owes for it
    function void close_frame(int unsigned len);
      logic [15:0] c, first, qty, v;
      logic [7:0] rsp[$];
      if (len == 0 || len > mrsri_pkg::FRAME_DEPTH) return;
      if (len == 1) begin
        push(1'b1, frame_mem[0], 1'b1);
        return;
      end
      if (frame_mem[0] != my_addr) return;
      c = 16'hFFFF;
      for (int k = 0; k < len - 2; k++) c = crc16(c, frame_mem[k]);
      if (frame_mem[len-2] != c[7:0] || frame_mem[len-1] != c[15:8]) return;
      if (frame_mem[1] != mrsri_pkg::FUNC_READ_INPUT || len != 8) return;
      first = {frame_mem[2], frame_mem[3]};
      qty = {frame_mem[4], frame_mem[5]};
      if (qty == 0 || qty > mrsri_pkg::MAX_QTY) return;
      if (32'(first) + 32'(qty) > mrsri_pkg::REG_COUNT) return;
      rsp.push_back(frame_mem[0]);
      rsp.push_back(mrsri_pkg::FUNC_READ_INPUT);
      rsp.push_back(8'(2 * qty));
      for (int i = 0; i < qty; i++) begin
        v = input_regs[first + i];
        rsp.push_back(v[15:8]);
        rsp.push_back(v[7:0]);
      end
      c = 16'hFFFF;
      foreach (rsp[k]) c = crc16(c, rsp[k]);
      rsp.push_back(c[7:0]);
      rsp.push_back(c[15:8]);
      foreach (rsp[k]) push(1'b0, rsp[k], k == rsp.size() - 1);
    endfunction

    function void note_item(logic [1:0] o, logic [7:0] b, logic fe,
                            logic [3:0] idx, logic [15:0] val);
      case (o)
        mrsri_pkg::OP_BYTE: begin
          timing = 0;
          if (!fe) begin
            if (rx_count < mrsri_pkg::FRAME_DEPTH) frame_mem[rx_count] = b;
            if (rx_count <= mrsri_pkg::FRAME_DEPTH) rx_count++;
            quiet_ticks = '0;
            timing = 1;
          end
        end
        mrsri_pkg::OP_TICK: begin
          if (timing) begin
            quiet_ticks = quiet_ticks + 8'd1;
            if (quiet_ticks == close_ticks) begin
              int unsigned n;
              n = rx_count;
              timing = 0;
              rx_count = 0;
              quiet_ticks = '0;
              close_frame(n);
            end
          end
        end
        mrsri_pkg::OP_WRITE: if (idx < mrsri_pkg::REG_COUNT) input_regs[idx] = val;
        default: ;
      endcase
    endfunction

    function void check_reply(reply_byte_t got);
      reply_byte_t exp;
      if (owed.size() == 0) begin
        $display("%0t: unexpected item kind=%0d byte=%h last=%0d", $time,
                 got.kind, got.out_byte, got.last);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (got.kind != exp.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, exp.kind, got.kind);
        errors++;
      end
      if (got.out_byte != exp.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, exp.out_byte, got.out_byte);
        errors++;
      end
      if (got.last != exp.last) begin
        $display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic [1:0] op = '0;
  logic [7:0] rx_byte = '0;
  logic frame_error = 0;
  logic [3:0] reg_index = '0;
  logic [15:0] reg_value = '0;
  logic out_valid, out_ready = 0;
  logic kind, last;
  logic [7:0] out_byte;

  reply_tracker tracker;
  bit calm;         // no idling on either side while set
  int idle_cycles = 0;

  always #10 clk = ~clk;

  modbus_rtu_slave_read_input_regs_core dut (.*);

  // Sink: accept and check replies, stalling at random
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        reply_byte_t r;
        r.kind = kind;
        r.out_byte = out_byte;
        r.last = last;
        tracker.check_reply(r);
      end
      out_ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // Watchdog: count cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one item, hold it until accepted, note it, then drop valid
  task automatic send_item(logic [1:0] o, logic [7:0] b, logic fe,
                           logic [3:0] idx, logic [15:0] val);
    while (!calm && $urandom_range(99) < 25) @(posedge clk);
    op <= o;
    rx_byte <= b;
    frame_error <= fe;
    reg_index <= idx;
    reg_value <= val;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_item(o, b, fe, idx, val);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, logic fe = 0);
    send_item(mrsri_pkg::OP_BYTE, b, fe, 4'($urandom), 16'($urandom));
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++)
      send_item(mrsri_pkg::OP_TICK, 8'($urandom), 1'($urandom), 4'($urandom),
                16'($urandom));
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    send_item(mrsri_pkg::OP_WRITE, 8'($urandom), 1'($urandom), idx, val);
  endtask

  // Wait for all owed bytes, then let the sequencer settle, then write
  task automatic write_cfg(logic [0:0] idx, logic [7:0] val);
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == mrsri_pkg::REG_SLAVE_ADDRESS) tracker.my_addr = val;
    else tracker.close_ticks = val;
  endtask

  // Send a read request, valid CRC unless corrupted, then close it with ticks
  task automatic send_request(logic [7:0] addr, logic [7:0] func, logic [15:0] first,
                              logic [15:0] qty, bit bad_crc, int len = 8);
    logic [7:0] f[$];
    logic [15:0] c;
    f = '{addr, func, first[15:8], first[7:0], qty[15:8], qty[7:0]};
    while (f.size() > len - 2) void'(f.pop_back());
    c = 16'hFFFF;
    foreach (f[k]) c = tracker.crc16(c, f[k]);
    if (bad_crc) c ^= 16'h0001 << $urandom_range(15);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    foreach (f[k]) send_byte(f[k]);
    send_ticks(tracker.close_ticks);
  endtask

  initial begin
    tracker = new();
    tracker.clear();
    calm = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: a one-tick timeout keeps requests short
    write_cfg(mrsri_pkg::REG_TIMEOUT_TICKS, 8'd1);
    write_reg(4'd0, 16'hFFFF);
    write_reg(4'd15, 16'h8001);
    write_reg(4'd7, 16'h1234);
    send_request(8'd1, mrsri_pkg::FUNC_READ_INPUT, 16'd0, 16'd16, 0);   // whole table
    send_request(8'd1, mrsri_pkg::FUNC_READ_INPUT, 16'd15, 16'd1, 0);   // top entry
    send_request(8'd1, mrsri_pkg::FUNC_READ_INPUT, 16'd15, 16'd2, 0);   // span past table
    send_request(8'd1, mrsri_pkg::FUNC_READ_INPUT, 16'd0, 16'd0, 0);    // quantity zero
    send_request(8'd1, mrsri_pkg::FUNC_READ_INPUT, 16'd0, 16'd17, 0);   // quantity too big
    send_request(8'd1, mrsri_pkg::FUNC_READ_INPUT, 16'd0, 16'd1, 1);    // bad CRC
    send_request(8'd9, mrsri_pkg::FUNC_READ_INPUT, 16'd0, 16'd1, 0);    // wrong address
    send_request(8'd1, 8'h03, 16'd0, 16'd1, 0);                         // other function
    send_request(8'd1, mrsri_pkg::FUNC_READ_INPUT, 16'd0, 16'd1, 0, 6); // short frame

    // Timer behavior with a two-tick timeout
    write_cfg(mrsri_pkg::REG_TIMEOUT_TICKS, 8'd2);
    send_byte(8'hA5);                                       // command byte
    send_ticks(3);                                          // extra tick: ignored
    send_byte(8'h00, 1);                                    // framing error only
    send_ticks(2);
    for (int i = 0; i < 10; i++) send_byte(8'($urandom));   // overlong frame
    send_ticks(2);
    send_item(2'd3, 8'hFF, 1, 4'hF, 16'hFFFF);              // unused op
    send_byte(8'h5A);
    send_ticks(1);
    send_byte(8'h11, 1);                                    // error pauses timer
    send_ticks(1);
    send_byte(8'h22);
    send_ticks(2);

    // Top address, with a long stretch of no idling on either side
    write_cfg(mrsri_pkg::REG_SLAVE_ADDRESS, 8'd255);
    calm = 1;
    send_request(8'd255, mrsri_pkg::FUNC_READ_INPUT, 16'd0, 16'd16, 0);
    while (tracker.owed.size() != 0) @(posedge clk);
    calm = 0;

    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tracker.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
